// File: src/ipf_pkg.sv
package ipf_pkg;

  // IP protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // statistics counter indexes
  localparam int NUM_STATS = 7;
  localparam int STAT_DEPTH = 8;
  localparam logic [2:0] ST_PACKETS = 3'd0;
  localparam logic [2:0] ST_BYTES   = 3'd1;
  localparam logic [2:0] ST_TCP     = 3'd2;
  localparam logic [2:0] ST_UDP     = 3'd3;
  localparam logic [2:0] ST_ICMP    = 3'd4;
  localparam logic [2:0] ST_OTHER   = 3'd5;
  localparam logic [2:0] ST_DROPPED = 3'd6;

  localparam logic [15:0] BLOCKED_PORT_RST = 16'd8080;
  localparam logic [15:0] OFFSET_MAX       = 16'hFFFF;
  localparam logic [15:0] MIN_IP_LEN       = 16'd20;
  localparam logic [16:0] TCP_HDR_LEN      = 17'd20;
  localparam logic [3:0]  IPV4_VERSION     = 4'd4;
  localparam logic [3:0]  MIN_IHL          = 4'd5;

  // one packet's worth of counter increments
  typedef struct packed {
    logic                 valid;
    logic [NUM_STATS-1:0] mask;
    logic [15:0]          len;
  } stat_upd_t;

endpackage

// File: src/ipf_stats.sv
module ipf_stats #(
  parameter int COUNTER_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ipf_pkg::stat_upd_t      upd,
  input  logic                    rd_en,
  input  logic [2:0]              rd_sel,
  output logic [COUNTER_BITS-1:0] rd_value
);

  logic [COUNTER_BITS-1:0] mem [ipf_pkg::STAT_DEPTH];
  logic [ipf_pkg::STAT_DEPTH-1:0] vld;

  logic [ipf_pkg::NUM_STATS-1:0] pend;
  logic [15:0]                   pend_len;
  logic [ipf_pkg::NUM_STATS-1:0] pick_oh;
  logic [2:0]                    pick_idx;
  logic                          pick_any;

  logic                    a_valid;
  logic [2:0]              a_idx;
  logic [COUNTER_BITS-1:0] rd_a;
  logic                    rd_a_vld;
  logic [COUNTER_BITS-1:0] wr_data;

  logic [COUNTER_BITS-1:0] rd_b;
  logic                    rd_b_vld;
  logic                    fwd_hit;
  logic [COUNTER_BITS-1:0] fwd_data;
  logic [COUNTER_BITS-1:0] fwd_add;
  logic                    sel_pend;

  function automatic logic [COUNTER_BITS-1:0] stat_amt(input logic [2:0] idx,
                                                       input logic [15:0] len);
    if (idx == ipf_pkg::ST_BYTES) return COUNTER_BITS'(len);
    return COUNTER_BITS'(1);
  endfunction

  // lowest pending counter goes next
  always_comb begin
    pick_oh  = '0;
    pick_idx = '0;
    pick_any = 1'b0;
    for (int i = ipf_pkg::NUM_STATS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick_oh  = '0;
        pick_oh[i] = 1'b1;
        pick_idx = 3'(i);
        pick_any = 1'b1;
      end
    end
  end

  assign wr_data  = (rd_a_vld ? rd_a : '0) + stat_amt(a_idx, pend_len);
  assign sel_pend = (rd_sel != ipf_pkg::ST_DROPPED + 3'd1) && pend[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      a_valid <= 1'b0;
      vld     <= '0;
    end else begin
      pend    <= (pend & ~pick_oh) | (upd.valid ? upd.mask : '0);
      a_valid <= pick_any;
      if (a_valid) begin
        vld[a_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.valid) begin
      pend_len <= upd.len;
    end
    // read side of the update: fetch, then add and write back
    if (pick_any) begin
      a_idx    <= pick_idx;
      rd_a     <= mem[pick_idx];
      rd_a_vld <= vld[pick_idx];
    end
    if (a_valid) begin
      mem[a_idx] <= wr_data;
    end
    // host read: catch a write-back in the same cycle or an increment still queued
    if (rd_en) begin
      rd_b     <= mem[rd_sel];
      rd_b_vld <= vld[rd_sel];
      fwd_hit  <= a_valid && (a_idx == rd_sel);
      fwd_data <= wr_data;
      fwd_add  <= sel_pend ? stat_amt(rd_sel, pend_len) : '0;
    end
  end

  assign rd_value = fwd_hit ? fwd_data : (rd_b_vld ? rd_b : '0) + fwd_add;

  a_upd_when_idle: assert property (@(posedge clk) disable iff (rst)
    upd.valid |-> (pend == '0) && !a_valid)
    else $error("counter update arrived while the previous one was draining");

  a_wb_index: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_idx != ipf_pkg::ST_DROPPED + 3'd1))
    else $error("write-back to the unused counter slot");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pend != '0) |=> ($countones(pend) < $countones($past(pend))) || $past(upd.valid))
    else $error("pending counter updates stalled");

endmodule

// File: src/ipv4_packet_filter.sv
// Pipeline: a transaction's result is registered in the s1 stage together with the counter
// memory read, then in the output register that drives the master side.
// Throughput: one transaction per cycle while the master side accepts results; the counter
// update of a packet drains through the read-modify-write port, one pending counter after another.
// Reset: synchronous, clears the packet capture state, the output stages and all
// counters (per-entry valid bits); blocked_port returns to 8080.
module ipv4_packet_filter #(
  parameter int COUNTER_BITS = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [7:0] data_byte, [10:8] counter_select
  input  logic         s_tuser,   // cmd
  input  logic         s_tlast,   // end_of_packet
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // [0] verdict, [1] event_valid, [9:2] event_protocol,
                                  // [41:10] src_addr, [73:42] dst_addr, [89:74] dst_port,
                                  // [137:90] counter_value
  input  logic         blocked_port_we,
  input  logic [15:0]  blocked_port_wdata
);

  logic [15:0] blocked_port;

  logic [15:0] byte_offset, byte_offset_next;
  logic [7:0]  version_and_length, version_and_length_next;
  logic [7:0]  protocol_seen, protocol_seen_next;
  logic [31:0] source_seen, source_seen_next;
  logic [31:0] destination_seen, destination_seen_next;
  logic [15:0] port_seen, port_seen_next;

  logic        accept, pkt_byte, s1_go;
  logic [7:0]  b;
  logic [3:0]  ihl;
  logic [6:0]  tcp_off;
  logic        ihl_ok, ip_ok, tcp_drop, icmp;
  logic [15:0] len;

  logic        s1_valid, s1_cmd, s1_verdict, s1_event;
  logic [7:0]  s1_proto;
  logic [31:0] s1_src, s1_dst;
  logic [15:0] s1_port;

  logic [COUNTER_BITS-1:0] cnt_value;
  logic [63:0]             cnt_wide;
  ipf_pkg::stat_upd_t      upd;

  assign s1_go    = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;
  assign pkt_byte = accept && !s_tuser;
  assign b        = s_tdata[7:0];

  // header capture for the current byte
  always_comb begin
    version_and_length_next = (byte_offset == 16'd0) ? b : version_and_length;
    protocol_seen_next      = (byte_offset == 16'd9) ? b : protocol_seen;
    source_seen_next        = (byte_offset >= 16'd12 && byte_offset <= 16'd15) ?
                              {source_seen[23:0], b} : source_seen;
    destination_seen_next   = (byte_offset >= 16'd16 && byte_offset <= 16'd19) ?
                              {destination_seen[23:0], b} : destination_seen;
    ihl     = version_and_length_next[3:0];
    tcp_off = {1'b0, ihl, 2'b00};
    ihl_ok  = ihl >= ipf_pkg::MIN_IHL;
    port_seen_next = port_seen;
    if (byte_offset != 16'd0 && ihl_ok) begin
      if (byte_offset == 16'(tcp_off + 7'd2)) begin
        port_seen_next = {b, port_seen[7:0]};
      end else if (byte_offset == 16'(tcp_off + 7'd3)) begin
        port_seen_next = {port_seen[15:8], b};
      end
    end
    len = (byte_offset != ipf_pkg::OFFSET_MAX) ? byte_offset + 16'd1 : byte_offset;
    byte_offset_next = len;
    ip_ok = (len >= ipf_pkg::MIN_IP_LEN) &&
            (version_and_length_next[7:4] == ipf_pkg::IPV4_VERSION);
    icmp  = protocol_seen_next == ipf_pkg::PROTO_ICMP;
    tcp_drop = (protocol_seen_next == ipf_pkg::PROTO_TCP) && ihl_ok &&
               ({1'b0, len} >= 17'(tcp_off) + ipf_pkg::TCP_HDR_LEN) &&
               (port_seen_next == blocked_port);
  end

  // counter increments for a valid IPv4 packet at end of packet
  always_comb begin
    upd.valid = pkt_byte && s_tlast && ip_ok;
    upd.len   = len;
    upd.mask  = '0;
    upd.mask[ipf_pkg::ST_PACKETS] = 1'b1;
    upd.mask[ipf_pkg::ST_BYTES]   = 1'b1;
    case (protocol_seen_next)
      ipf_pkg::PROTO_TCP:  upd.mask[ipf_pkg::ST_TCP]  = 1'b1;
      ipf_pkg::PROTO_UDP:  upd.mask[ipf_pkg::ST_UDP]  = 1'b1;
      ipf_pkg::PROTO_ICMP: upd.mask[ipf_pkg::ST_ICMP] = 1'b1;
      default:             upd.mask[ipf_pkg::ST_OTHER] = 1'b1;
    endcase
    upd.mask[ipf_pkg::ST_DROPPED] = icmp || tcp_drop;
  end

  ipf_stats #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_stats (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .rd_en   (accept && s_tuser),
    .rd_sel  (s_tdata[10:8]),
    .rd_value(cnt_value)
  );

  assign cnt_wide = 64'(cnt_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_port       <= ipf_pkg::BLOCKED_PORT_RST;
      byte_offset        <= '0;
      version_and_length <= '0;
      protocol_seen      <= '0;
      source_seen        <= '0;
      destination_seen   <= '0;
      port_seen          <= '0;
      s1_valid           <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      if (blocked_port_we) begin
        blocked_port <= blocked_port_wdata;
      end
      if (pkt_byte) begin
        if (s_tlast) begin
          // drop the per-packet capture
          byte_offset        <= '0;
          version_and_length <= '0;
          protocol_seen      <= '0;
          source_seen        <= '0;
          destination_seen   <= '0;
          port_seen          <= '0;
        end else begin
          byte_offset        <= byte_offset_next;
          version_and_length <= version_and_length_next;
          protocol_seen      <= protocol_seen_next;
          source_seen        <= source_seen_next;
          destination_seen   <= destination_seen_next;
          port_seen          <= port_seen_next;
        end
      end
      if (s_tready) begin
        s1_valid <= accept && (s_tuser || s_tlast);
      end
      if (s1_go) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= s_tuser;
      s1_verdict <= 1'b0;
      s1_event   <= 1'b0;
      s1_proto   <= '0;
      s1_src     <= '0;
      s1_dst     <= '0;
      s1_port    <= '0;
      if (!s_tuser) begin
        s1_verdict <= 1'b1;
        if (ip_ok && (icmp || tcp_drop)) begin
          s1_verdict <= 1'b0;
          s1_event   <= 1'b1;
          s1_proto   <= icmp ? ipf_pkg::PROTO_ICMP : ipf_pkg::PROTO_TCP;
          s1_src     <= source_seen_next;
          s1_dst     <= destination_seen_next;
          s1_port    <= icmp ? 16'd0 : port_seen_next;
        end
      end
    end
    if (s1_go && s1_valid) begin
      m_tdata[0]       <= s1_verdict;
      m_tdata[1]       <= s1_event;
      m_tdata[9:2]     <= s1_proto;
      m_tdata[41:10]   <= s1_src;
      m_tdata[73:42]   <= s1_dst;
      m_tdata[89:74]   <= s1_port;
      m_tdata[137:90]  <= s1_cmd ? cnt_wide[47:0] : 48'd0;
      m_tdata[143:138] <= '0;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_cmd) && $stable(s1_verdict))
    else $error("stage 1 result lost while the output stalled");

  a_mid_packet: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tuser && !s_tlast |=> !s1_valid)
    else $error("result made for a byte that does not end a packet");

  a_event_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_event |-> !s1_verdict && !s1_cmd)
    else $error("event reported on an accepted packet or a counter read");

endmodule

// File: verif/ipv4_filter_checker.sv
`timescale 1ns / 1ps
module ipv4_filter_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  s_tdata,   // [7:0] data_byte, [10:8] counter_select
  input  logic         s_tuser,   // cmd
  input  logic         s_tlast,   // end_of_packet
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,   // [0] verdict, [1] event_valid, [9:2] event_protocol,
                                  // [41:10] src_addr, [73:42] dst_addr, [89:74] dst_port,
                                  // [137:90] counter_value
  input  logic         blocked_port_we,
  input  logic [15:0]  blocked_port_wdata,
  output int           errors,
  output int           outstanding
);

  localparam logic VERDICT_DROP   = 1'b0;
  localparam logic VERDICT_ACCEPT = 1'b1;

  typedef struct packed {
    logic        verdict;
    logic        event_valid;
    logic [7:0]  event_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [47:0] counter_value;
  } filter_result_t;

  // per-packet capture
  logic [15:0] pkt_len;
  logic [7:0]  hdr_byte0;
  logic [7:0]  proto_byte;
  logic [31:0] src_word;
  logic [31:0] dst_word;
  logic [15:0] port_word;
  logic [47:0] stat_count [ipf_pkg::NUM_STATS];
  logic [15:0] cur_blocked_port;

  filter_result_t expected_results[$];
  int mismatch_count = 0;
  int pending_count = 0;

  assign errors = mismatch_count;
  assign outstanding = pending_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  task automatic bump(input logic [2:0] idx, input logic [47:0] amount);
    stat_count[idx] = stat_count[idx] + amount;
  endtask

  task automatic clear_packet();
    pkt_len = '0;
    hdr_byte0 = '0;
    proto_byte = '0;
    src_word = '0;
    dst_word = '0;
    port_word = '0;
  endtask

  task automatic predict_transaction(input logic read_cmd, input logic [7:0] b,
                                     input logic eop, input logic [2:0] sel);
    filter_result_t res;
    logic [3:0] ihl;
    int hdr_off;
    int off;
    res = '0;
    if (read_cmd) begin
      if (sel < ipf_pkg::NUM_STATS) res.counter_value = stat_count[sel];
      expected_results.push_back(res);
      return;
    end
    off = int'(pkt_len);
    if (off == 0) hdr_byte0 = b;
    else if (off == 9) proto_byte = b;
    else if (off >= 12 && off <= 15) src_word = {src_word[23:0], b};
    else if (off >= 16 && off <= 19) dst_word = {dst_word[23:0], b};
    ihl = hdr_byte0[3:0];
    hdr_off = int'(ihl) * 4;
    if (off >= 1 && ihl >= ipf_pkg::MIN_IHL) begin
      if (off == hdr_off + 2) port_word[15:8] = b;
      else if (off == hdr_off + 3) port_word[7:0] = b;
    end
    // length sticks at the top of the offset range
    if (pkt_len != ipf_pkg::OFFSET_MAX) pkt_len++;
    if (!eop) return;

    res.verdict = VERDICT_ACCEPT;
    if (pkt_len >= ipf_pkg::MIN_IP_LEN && hdr_byte0[7:4] == ipf_pkg::IPV4_VERSION) begin
      bump(ipf_pkg::ST_PACKETS, 48'd1);
      bump(ipf_pkg::ST_BYTES, {32'd0, pkt_len});
      case (proto_byte)
        ipf_pkg::PROTO_TCP: begin
          bump(ipf_pkg::ST_TCP, 48'd1);
          if (ihl >= ipf_pkg::MIN_IHL &&
              int'(pkt_len) >= hdr_off + int'(ipf_pkg::TCP_HDR_LEN) &&
              port_word == cur_blocked_port) begin
            bump(ipf_pkg::ST_DROPPED, 48'd1);
            res.verdict = VERDICT_DROP;
            res.event_valid = 1'b1;
            res.event_protocol = ipf_pkg::PROTO_TCP;
            res.src_addr = src_word;
            res.dst_addr = dst_word;
            res.dst_port = port_word;
          end
        end
        ipf_pkg::PROTO_UDP: bump(ipf_pkg::ST_UDP, 48'd1);
        ipf_pkg::PROTO_ICMP: begin
          bump(ipf_pkg::ST_ICMP, 48'd1);
          bump(ipf_pkg::ST_DROPPED, 48'd1);
          res.verdict = VERDICT_DROP;
          res.event_valid = 1'b1;
          res.event_protocol = ipf_pkg::PROTO_ICMP;
          res.src_addr = src_word;
          res.dst_addr = dst_word;
        end
        default: bump(ipf_pkg::ST_OTHER, 48'd1);
      endcase
    end
    expected_results.push_back(res);
    clear_packet();
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    if (rst) begin
      clear_packet();
      for (int i = 0; i < ipf_pkg::NUM_STATS; i++) stat_count[i] = '0;
      cur_blocked_port = ipf_pkg::BLOCKED_PORT_RST;
      expected_results.delete();
    end else begin
      if (blocked_port_we) cur_blocked_port = blocked_port_wdata;
      if (s_tvalid && s_tready)
        predict_transaction(s_tuser, s_tdata[7:0], s_tlast, s_tdata[10:8]);
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("verdict", 64'(want.verdict), 64'(m_tdata[0]));
          check_field("event_valid", 64'(want.event_valid), 64'(m_tdata[1]));
          check_field("event_protocol", 64'(want.event_protocol), 64'(m_tdata[9:2]));
          check_field("src_addr", 64'(want.src_addr), 64'(m_tdata[41:10]));
          check_field("dst_addr", 64'(want.dst_addr), 64'(m_tdata[73:42]));
          check_field("dst_port", 64'(want.dst_port), 64'(m_tdata[89:74]));
          check_field("counter_value", 64'(want.counter_value), 64'(m_tdata[137:90]));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: verif/ipv4_packet_filter_test.sv
`timescale 1ns / 1ps
module ipv4_packet_filter_test;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam int PHASE_ITEMS = 180;

  typedef enum int {
    K_ICMP,
    K_TCP_BLOCKED,
    K_TCP_OPEN,
    K_TCP_SHORT,
    K_UDP,
    K_OTHER_PROTO,
    K_NOT_V4,
    K_RUNT,
    K_IHL_LOW,
    K_NOISE
  } pkt_kind_t;
  localparam int NUM_KINDS = 10;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;    // [7:0] data_byte, [10:8] counter_select
  logic         s_tuser = 1'b0;  // cmd
  logic         s_tlast = 1'b0;  // end_of_packet
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;         // [0] verdict, [1] event_valid, [9:2] event_protocol,
                                 // [41:10] src_addr, [73:42] dst_addr, [89:74] dst_port,
                                 // [137:90] counter_value
  logic         blocked_port_we = 1'b0;
  logic [15:0]  blocked_port_wdata = '0;

  int errors;
  int outstanding;

  bit no_idle = 1'b0;
  logic [15:0] current_blocked = ipf_pkg::BLOCKED_PORT_RST;
  logic [7:0] byte_stream[$];
  int items_sent = 0;

  ipv4_packet_filter u_top (
    .clk                (clk),
    .rst                (rst),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .s_tlast            (s_tlast),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .blocked_port_we    (blocked_port_we),
    .blocked_port_wdata (blocked_port_wdata)
  );

  ipv4_filter_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .s_tlast            (s_tlast),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .blocked_port_we    (blocked_port_we),
    .blocked_port_wdata (blocked_port_wdata),
    .errors             (errors),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stall before each transaction
  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic read_cmd, input logic [7:0] b, input logic eop,
                           input logic [2:0] sel);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= read_cmd;
    s_tlast <= eop;
    s_tdata <= {5'd0, sel, b};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_random_read();
    send_item(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              3'($urandom_range(0, 7)));
  endtask

  // hold off until every result is back, then let the counter update settle
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_blocked_port(input logic [15:0] port);
    blocked_port_we <= 1'b1;
    blocked_port_wdata <= port;
    current_blocked = port;
    @(negedge clk);
    blocked_port_we <= 1'b0;
  endtask

  task automatic build_packet(input pkt_kind_t kind, input int pad);
    logic [3:0] ver;
    logic [3:0] ihl;
    logic [7:0] proto;
    logic [15:0] port;
    int hdr;
    int len;
    ver = ipf_pkg::IPV4_VERSION;
    ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : ipf_pkg::MIN_IHL;
    proto = ipf_pkg::PROTO_TCP;
    port = current_blocked;
    case (kind)
      K_ICMP: proto = ipf_pkg::PROTO_ICMP;
      K_UDP: proto = ipf_pkg::PROTO_UDP;
      K_OTHER_PROTO: begin
        do proto = 8'($urandom_range(0, 255));
        while (proto == ipf_pkg::PROTO_TCP || proto == ipf_pkg::PROTO_UDP ||
               proto == ipf_pkg::PROTO_ICMP);
      end
      K_TCP_OPEN: begin
        do port = 16'($urandom_range(0, 65535)); while (port == current_blocked);
      end
      K_NOT_V4, K_RUNT: begin
        if (kind == K_NOT_V4) begin
          do ver = 4'($urandom_range(0, 15)); while (ver == ipf_pkg::IPV4_VERSION);
        end
        proto = $urandom_range(0, 1) ? ipf_pkg::PROTO_ICMP : ipf_pkg::PROTO_TCP;
      end
      // blocked port sits where a TCP header would be, but must not be looked at
      K_IHL_LOW: ihl = 4'($urandom_range(0, 4));
      default: ;
    endcase
    hdr = (ihl < ipf_pkg::MIN_IHL) ? int'(ipf_pkg::MIN_IP_LEN) : int'(ihl) * 4;
    case (kind)
      K_TCP_BLOCKED, K_TCP_OPEN, K_IHL_LOW: len = hdr + 20 + $urandom_range(0, 6);
      K_TCP_SHORT: len = $urandom_range(hdr, hdr + 19);
      K_RUNT: len = $urandom_range(1, 19);
      K_NOISE: len = $urandom_range(1, 40);
      default: len = hdr + $urandom_range(0, 12);
    endcase
    len += pad;
    byte_stream.delete();
    repeat (len) byte_stream.push_back(8'($urandom_range(0, 255)));
    if (kind != K_NOISE) begin
      byte_stream[0] = {ver, ihl};
      if (len > 9) byte_stream[9] = proto;
      if (len > hdr + 2) byte_stream[hdr + 2] = port[15:8];
      if (len > hdr + 3) byte_stream[hdr + 3] = port[7:0];
    end
  endtask

  // counter reads are mixed in between packet bytes now and then
  task automatic send_packet();
    for (int i = 0; i < byte_stream.size(); i++) begin
      if ($urandom_range(0, 13) == 0) send_random_read();
      send_item(CMD_BYTE, byte_stream[i], i == byte_stream.size() - 1,
                3'($urandom_range(0, 7)));
    end
  endtask

  initial begin : stimulus
    int k;
    int phase;
    int phase_start;
    int packets_built;
    pkt_kind_t kind;
    packets_built = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every counter select, including the unused one
    for (k = 0; k < 8; k++) send_item(CMD_READ, k[0] ? 8'hFF : 8'h00, k[0], 3'(k));
    send_item(CMD_BYTE, 8'hFF, 1'b1, 3'd7);
    send_item(CMD_BYTE, 8'h00, 1'b0, 3'd0);
    send_item(CMD_BYTE, 8'h45, 1'b1, 3'd5);
    send_item(CMD_READ, 8'h00, 1'b0, ipf_pkg::ST_PACKETS);

    for (phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        wait_quiet();
        case (phase)
          1: write_blocked_port(16'h0000);
          2: write_blocked_port(16'hFFFF);
          default: write_blocked_port(16'($urandom_range(0, 65535)));
        endcase
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
        kind = (packets_built < NUM_KINDS) ? pkt_kind_t'(packets_built)
                                           : pkt_kind_t'($urandom_range(0, NUM_KINDS - 1));
        packets_built++;
        build_packet(kind, 0);
        send_packet();
      end
    end

    no_idle = 1'b0;
    for (k = 0; k < 8; k++) send_item(CMD_READ, 8'h00, 1'b0, 3'(k));

    wait_quiet();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
